/* hw/rtl/ttip_pkg.sv */
package ttip_pkg;

    localparam int MAX_LEN     = 4096;
    localparam int IDX_W       = $clog2(MAX_LEN);
    localparam int END_W       = 12;
    localparam int BASE_W      = 6;
    localparam int VALUE_W     = 32;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 6;

    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_SELECT   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNSIGNED_MODE = 1'd1;

    localparam logic [BASE_W-1:0] MAX_BASE = 6'd36;

    typedef struct packed {
        logic       start_of_string;
        logic [7:0] character;
    } char_beat_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [END_W-1:0]   end_index;
        logic               no_digits;
        logic               range_error;
        logic               bad_base;
    } result_beat_t;

endpackage

/* hw/rtl/text_to_integer_parser_unit.sv */
// channel   dir  handshake                     payload
// char      in   char_valid / char_ready       char_beat   (ttip_pkg::char_beat_t)
// result    out  result_valid / result_ready   result_beat (ttip_pkg::result_beat_t)
// cfg       in   cfg_we (no wait)              cfg_index, cfg_data
//
// One character per cycle; the per-character step (digit decode, 32x6 multiply-add,
// overflow check) sits between the parse state registers and the result register.
// The ending beat's result is registered (skid entry if the result register is full).
// A two-entry output (result register plus skid) keeps char_ready high while one
// result waits; char_ready drops only when both entries are full.
// rst_n clears parse state to idle, base_select to 0 and unsigned_mode to 1.
module text_to_integer_parser_unit
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 char_valid,
    output logic                                 char_ready,
    input  ttip_pkg::char_beat_t                 char_beat,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output ttip_pkg::result_beat_t               result_beat,
    input  logic                                 cfg_we,
    input  logic [ttip_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ttip_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_SPACE  = 3'd1;
    localparam logic [2:0] PH_FIRST  = 3'd2;
    localparam logic [2:0] PH_ZERO   = 3'd3;
    localparam logic [2:0] PH_HEXPFX = 3'd4;
    localparam logic [2:0] PH_DIGITS = 3'd5;

    localparam int PROD_W = ttip_pkg::VALUE_W + ttip_pkg::BASE_W;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LX    = 8'h78;

    localparam logic [ttip_pkg::BASE_W-1:0] BASE_8   = 6'd8;
    localparam logic [ttip_pkg::BASE_W-1:0] BASE_10  = 6'd10;
    localparam logic [ttip_pkg::BASE_W-1:0] BASE_16  = 6'd16;
    localparam logic [ttip_pkg::BASE_W-1:0] DV_NONE  = 6'd63;

    localparam logic [ttip_pkg::VALUE_W-1:0] SMIN = 32'h8000_0000;
    localparam logic [ttip_pkg::VALUE_W-1:0] SMAX = 32'h7FFF_FFFF;
    localparam logic [ttip_pkg::VALUE_W-1:0] UMAX = 32'hFFFF_FFFF;

    localparam logic [ttip_pkg::IDX_W-1:0] IDX_LAST = ttip_pkg::IDX_W'(ttip_pkg::MAX_LEN - 1);

    logic [ttip_pkg::BASE_W-1:0]  base_select_reg;
    logic                         unsigned_mode_reg;

    logic [2:0]                   phase_reg,  phase_next;
    logic [ttip_pkg::VALUE_W-1:0] acc_reg,    acc_next;
    logic [ttip_pkg::BASE_W-1:0]  eb_reg,     eb_next;
    logic                         neg_reg,    neg_next;
    logic                         ds_reg,     ds_next;
    logic                         ovf_reg,    ovf_next;
    logic [ttip_pkg::IDX_W-1:0]   idx_reg,    idx_next;

    logic                         out_valid_reg, out_valid_next;
    logic                         skid_valid_reg, skid_valid_next;
    ttip_pkg::result_beat_t       out_reg, skid_reg;

    logic                         char_fire;
    logic                         pop;
    logic                         push;
    ttip_pkg::result_beat_t       res_new;

    logic [7:0]                   c;
    logic [2:0]                   ph_w;
    logic                         active;
    logic                         do_digit;
    logic                         do_finish;
    logic [ttip_pkg::BASE_W-1:0]  dv;
    logic [PROD_W-1:0]            prod;
    logic [ttip_pkg::VALUE_W-1:0] fv;
    logic                         sat;
    logic [ttip_pkg::END_W+ttip_pkg::IDX_W-1:0] end_ext;

    assign char_ready   = !skid_valid_reg;
    assign char_fire    = char_valid && char_ready;
    assign pop          = out_valid_reg && result_ready;
    assign result_valid = out_valid_reg;
    assign result_beat  = out_reg;

    always_comb
    begin
        c          = char_beat.character;
        phase_next = phase_reg;
        acc_next   = acc_reg;
        eb_next    = eb_reg;
        neg_next   = neg_reg;
        ds_next    = ds_reg;
        ovf_next   = ovf_reg;
        idx_next   = idx_reg;
        push       = 1'b0;
        res_new    = '0;
        ph_w       = phase_reg;
        active     = 1'b0;
        do_digit   = 1'b0;
        do_finish  = 1'b0;
        dv         = DV_NONE;
        prod       = '0;
        fv         = '0;
        sat        = 1'b0;
        end_ext    = '0;

        if (char_beat.start_of_string)
        begin
            acc_next = '0;
            neg_next = 1'b0;
            ds_next  = 1'b0;
            ovf_next = 1'b0;
            idx_next = '0;
            eb_next  = base_select_reg;
            if (base_select_reg == 6'd1 || base_select_reg > ttip_pkg::MAX_BASE)
            begin
                phase_next          = PH_IDLE;
                push                = 1'b1;
                res_new.no_digits   = 1'b1;
                res_new.bad_base    = 1'b1;
            end
            else
            begin
                ph_w   = PH_SPACE;
                active = 1'b1;
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            active = 1'b1;
        end

        if (active)
        begin
            unique case (ph_w)
                PH_SPACE, PH_FIRST:
                begin
                    if (ph_w == PH_SPACE && (c == CH_SPACE || c == CH_TAB || c == CH_LF))
                    begin
                        phase_next = PH_SPACE;
                    end
                    else if (ph_w == PH_SPACE && c == CH_MINUS)
                    begin
                        neg_next   = 1'b1;
                        phase_next = PH_FIRST;
                    end
                    else if (ph_w == PH_SPACE && c == CH_PLUS)
                    begin
                        phase_next = PH_FIRST;
                    end
                    else if ((eb_next == '0 || eb_next == BASE_16) && c == CH_0)
                    begin
                        phase_next = PH_ZERO;
                    end
                    else
                    begin
                        if (eb_next == '0)
                            eb_next = BASE_10;
                        do_digit = 1'b1;
                    end
                end
                PH_ZERO:
                begin
                    if (c == CH_UX || c == CH_LX)
                    begin
                        eb_next    = BASE_16;
                        phase_next = PH_HEXPFX;
                    end
                    else
                    begin
                        if (eb_next == '0)
                            eb_next = BASE_8;
                        ds_next  = 1'b1;
                        do_digit = 1'b1;
                    end
                end
                PH_HEXPFX, PH_DIGITS:
                begin
                    do_digit = 1'b1;
                end
                default:
                begin
                    do_digit = 1'b1;
                end
            endcase

            if (do_digit)
            begin
                if (c >= CH_0 && c <= CH_9)
                    dv = ttip_pkg::BASE_W'(c - CH_0);
                else if (c >= CH_UA && c <= CH_UZ)
                    dv = ttip_pkg::BASE_W'(c - CH_UA + 8'd10);
                else if (c >= CH_LA && c <= CH_LZ)
                    dv = ttip_pkg::BASE_W'(c - CH_LA + 8'd10);
                else
                    dv = DV_NONE;

                if (dv >= eb_next)
                begin
                    do_finish = 1'b1;
                end
                else
                begin
                    ds_next    = 1'b1;
                    prod       = PROD_W'(acc_next) * PROD_W'(eb_next) + PROD_W'(dv);
                    phase_next = PH_DIGITS;
                    if (prod[PROD_W-1:ttip_pkg::VALUE_W] != '0)
                        ovf_next = 1'b1;
                    else
                        acc_next = prod[ttip_pkg::VALUE_W-1:0];
                end
            end

            if (do_finish)
            begin
                phase_next = PH_IDLE;
                push       = 1'b1;
                end_ext    = {{ttip_pkg::END_W{1'b0}}, idx_next};
                if (!ds_next)
                begin
                    res_new.no_digits = 1'b1;
                end
                else
                begin
                    // no digit is taken in the ending beat, so the stored value is final
                    fv  = acc_reg;
                    sat = ovf_reg;
                    if (!unsigned_mode_reg)
                    begin
                        if (neg_next && fv > SMIN)
                            sat = 1'b1;
                        if (!neg_next && fv[ttip_pkg::VALUE_W-1])
                            sat = 1'b1;
                    end
                    if (sat)
                        fv = unsigned_mode_reg ? UMAX : (neg_next ? SMIN : SMAX);
                    if (neg_next && !(sat && unsigned_mode_reg))
                        fv = '0 - fv;
                    res_new.value       = fv;
                    res_new.end_index   = end_ext[ttip_pkg::END_W-1:0];
                    res_new.range_error = sat;
                end
            end

            if (idx_next < IDX_LAST)
                idx_next = idx_next + 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = (out_valid_reg && !pop) || (char_fire && push);
            if (char_fire && push && out_valid_reg && !pop)
                skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_select_reg   <= '0;
            unsigned_mode_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ttip_pkg::CFG_BASE_SELECT:   base_select_reg   <= cfg_data;
                ttip_pkg::CFG_UNSIGNED_MODE: unsigned_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            acc_reg        <= '0;
            eb_reg         <= '0;
            neg_reg        <= 1'b0;
            ds_reg         <= 1'b0;
            ovf_reg        <= 1'b0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (char_fire)
            begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                eb_reg    <= eb_next;
                neg_reg   <= neg_next;
                ds_reg    <= ds_next;
                ovf_reg   <= ovf_next;
                idx_reg   <= idx_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_reg <= skid_reg;
        end
        else if (char_fire && push)
        begin
            if (!out_valid_reg || pop)
                out_reg <= res_new;
            else
                skid_reg <= res_new;
        end
    end

    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while result register empty");

    a_no_digits_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.no_digits |->
            out_reg.value == '0 && out_reg.end_index == '0 && !out_reg.range_error)
        else $error("no-digit result carries nonzero fields");

    a_bad_base_no_digits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.bad_base |-> out_reg.no_digits)
        else $error("bad base result without no_digits");

    a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        char_fire && push |=> phase_reg == PH_IDLE)
        else $error("parser not idle after emitting a result");

    a_skid_fill_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        !skid_valid_reg && char_fire && push && out_valid_reg && !result_ready |=>
            skid_valid_reg && !char_ready)
        else $error("result lost when output register was full");

endmodule

/* sim/ttip_result_checker.sv */
module ttip_result_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             char_valid,
    input  logic                             char_ready,
    input  ttip_pkg::char_beat_t             char_beat,
    input  logic                             result_valid,
    input  logic                             result_ready,
    input  ttip_pkg::result_beat_t           result_beat,
    input  logic                             cfg_we,
    input  logic [ttip_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ttip_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               mismatches,
    output int                               results_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_LZ    = 8'h7A;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SPACE,
        PH_FIRST,
        PH_ZERO,
        PH_HEXPFX,
        PH_DIGITS
    } parse_phase_t;

    logic [ttip_pkg::BASE_W-1:0]  base_sel;
    logic                         uns_mode;
    parse_phase_t                 ph;
    logic [ttip_pkg::VALUE_W-1:0] acc;
    logic [ttip_pkg::BASE_W-1:0]  eff_base;
    logic                         neg;
    logic                         got_digit;
    logic                         ovf;
    logic [ttip_pkg::IDX_W-1:0]   pos;

    ttip_pkg::result_beat_t expected_results[$];

    task automatic close_string(input logic [ttip_pkg::IDX_W-1:0] at,
                                output ttip_pkg::result_beat_t r);
        logic [ttip_pkg::VALUE_W-1:0] v;
        logic                         sat;
        v   = acc;
        sat = ovf;
        ph  = PH_IDLE;
        r   = '0;
        if (!got_digit)
            r.no_digits = 1'b1;
        else
        begin
            if (!uns_mode && ((neg && v > 32'h8000_0000) || (!neg && v > 32'h7FFF_FFFF)))
                sat = 1'b1;
            r.end_index   = ttip_pkg::END_W'(at);
            r.range_error = sat;
            if (sat && uns_mode)
                r.value = '1;
            else
            begin
                if (sat)
                    v = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                r.value = neg ? 32'd0 - v : v;
            end
        end
    endtask

    task automatic take_digit(input logic [7:0] c, inout bit emit,
                              inout ttip_pkg::result_beat_t r);
        int          dv;
        logic [63:0] t;
        if (c >= CH_0 && c <= CH_9)
            dv = int'(c - CH_0);
        else if (c >= CH_UA && c <= CH_UZ)
            dv = int'(c - CH_UA) + 10;
        else if (c >= CH_LA && c <= CH_LZ)
            dv = int'(c - CH_LA) + 10;
        else
            dv = 99;
        if (dv >= int'(eff_base))
        begin
            close_string(pos, r);
            emit = 1'b1;
        end
        else
        begin
            got_digit = 1'b1;
            t = {32'd0, acc} * {58'd0, eff_base} + 64'(dv);
            if (t > 64'hFFFF_FFFF)
                ovf = 1'b1;
            else
                acc = t[31:0];
            ph = PH_DIGITS;
        end
    endtask

    task automatic take_first(input logic [7:0] c, inout bit emit,
                              inout ttip_pkg::result_beat_t r);
        if ((eff_base == 6'd0 || eff_base == 6'd16) && c == CH_0)
            ph = PH_ZERO;
        else
        begin
            if (eff_base == 6'd0)
                eff_base = 6'd10;
            take_digit(c, emit, r);
        end
    endtask

    task automatic predict_char(input ttip_pkg::char_beat_t b, output bit emit,
                                output ttip_pkg::result_beat_t r);
        bit         active;
        logic [7:0] c;
        c      = b.character;
        emit   = 1'b0;
        r      = '0;
        active = 1'b1;
        if (b.start_of_string)
        begin
            acc       = '0;
            neg       = 1'b0;
            got_digit = 1'b0;
            ovf       = 1'b0;
            pos       = '0;
            eff_base  = base_sel;
            if (base_sel == 6'd1 || base_sel > ttip_pkg::MAX_BASE)
            begin
                ph          = PH_IDLE;
                r.no_digits = 1'b1;
                r.bad_base  = 1'b1;
                emit        = 1'b1;
                active      = 1'b0;
            end
            else
                ph = PH_SPACE;
        end
        else if (ph == PH_IDLE)
            active = 1'b0;

        if (active)
        begin
            case (ph)
                PH_SPACE:
                begin
                    if (c == CH_SPACE || c == CH_TAB || c == CH_NL)
                        ;
                    else if (c == CH_MINUS)
                    begin
                        neg = 1'b1;
                        ph  = PH_FIRST;
                    end
                    else if (c == CH_PLUS)
                        ph = PH_FIRST;
                    else
                        take_first(c, emit, r);
                end
                PH_FIRST:
                    take_first(c, emit, r);
                PH_ZERO:
                begin
                    if (c == CH_LX || c == CH_UX)
                    begin
                        eff_base = 6'd16;
                        ph       = PH_HEXPFX;
                    end
                    else
                    begin
                        if (eff_base == 6'd0)
                            eff_base = 6'd8;
                        got_digit = 1'b1;
                        take_digit(c, emit, r);
                    end
                end
                default:
                    take_digit(c, emit, r);
            endcase
            if (pos < ttip_pkg::MAX_LEN - 1)
                pos = pos + 1'b1;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s expected %0h actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        ttip_pkg::result_beat_t want;
        ttip_pkg::result_beat_t fresh;
        bit                     emit;
        if (!rst_n)
        begin
            base_sel  = '0;
            uns_mode  = 1'b1;
            ph        = PH_IDLE;
            acc       = '0;
            eff_base  = '0;
            neg       = 1'b0;
            got_digit = 1'b0;
            ovf       = 1'b0;
            pos       = '0;
            expected_results.delete();
            mismatches      = 0;
            results_pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == ttip_pkg::CFG_BASE_SELECT)
                    base_sel = cfg_data[ttip_pkg::BASE_W-1:0];
                else if (cfg_index == ttip_pkg::CFG_UNSIGNED_MODE)
                    uns_mode = cfg_data[0];
            end
            // pop before push: a result never leaves in the beat that causes it
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result beat with nothing expected: value %0h", result_beat.value);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("value", want.value, result_beat.value);
                    check_field("end_index", 32'(want.end_index), 32'(result_beat.end_index));
                    check_field("no_digits", 32'(want.no_digits), 32'(result_beat.no_digits));
                    check_field("range_error", 32'(want.range_error),
                                32'(result_beat.range_error));
                    check_field("bad_base", 32'(want.bad_base), 32'(result_beat.bad_base));
                end
            end
            if (char_valid && char_ready)
            begin
                predict_char(char_beat, emit, fresh);
                if (emit)
                    expected_results.push_back(fresh);
            end
            results_pending = expected_results.size();
        end
    end

endmodule

/* sim/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT  = 2000;
    localparam int ITEM_TARGET  = 1000;
    localparam int PHASE_ITEMS  = 95;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LX    = 8'h78;

    logic                             clk;
    logic                             rst_n;
    logic                             char_valid;
    logic                             char_ready;
    ttip_pkg::char_beat_t             char_beat;
    logic                             result_valid;
    logic                             result_ready;
    ttip_pkg::result_beat_t           result_beat;
    logic                             cfg_we;
    logic [ttip_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [ttip_pkg::CFG_DATA_W-1:0]  cfg_data;

    int  mismatches;
    int  results_pending;
    int  items_sent;
    int  quiet_cycles;
    bit  idling;

    logic [7:0] text_q[$];

    text_to_integer_parser_unit DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_ready   (char_ready),
        .char_beat    (char_beat),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_beat  (result_beat),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    ttip_result_checker u_scoreboard
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .char_valid      (char_valid),
        .char_ready      (char_ready),
        .char_beat       (char_beat),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .result_beat     (result_beat),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .results_pending (results_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_ready <= !(idling && $urandom_range(99) < 13);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (char_valid && char_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // one character beat; returns at the falling edge after acceptance, valid left high
    task automatic send_beat(input logic sos, input logic [7:0] ch);
        while (idling && $urandom_range(99) < 13)
        begin
            char_valid <= 1'b0;
            @(negedge clk);
        end
        char_valid <= 1'b1;
        char_beat  <= {sos, ch};
        @(posedge clk);
        while (!char_ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_queued();
        foreach (text_q[i])
            send_beat(i == 0, text_q[i]);
    endtask

    // term < 0: leave the string open
    task automatic send_text(input string t, input int term);
        for (int i = 0; i < t.len(); i++)
            send_beat(i == 0, t[i]);
        if (term >= 0)
            send_beat(1'b0, term[7:0]);
    endtask

    task automatic drain();
        char_valid <= 1'b0;
        @(negedge clk);
        while (results_pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_config(input logic [5:0] bsel, input logic uns);
        cfg_we    <= 1'b1;
        cfg_index <= ttip_pkg::CFG_BASE_SELECT;
        cfg_data  <= bsel;
        @(negedge clk);
        cfg_index <= ttip_pkg::CFG_UNSIGNED_MODE;
        cfg_data  <= {5'($urandom_range(31)), uns};
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] digit_glyph(input int d);
        if (d < 10)
            return CH_0 + 8'(d);
        return ($urandom_range(1) ? CH_UA : CH_LA) + 8'(d - 10);
    endfunction

    // builds a number string for base_select bsel into text_q
    task automatic make_number(input logic [5:0] bsel);
        int          b;
        int          n;
        logic [63:0] v;
        logic [7:0]  rev[$];
        text_q.delete();
        n = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (n)
        begin
            case ($urandom_range(2))
                0:       text_q.push_back(CH_SPACE);
                1:       text_q.push_back(CH_TAB);
                default: text_q.push_back(CH_NL);
            endcase
        end
        case ($urandom_range(3))
            0:       text_q.push_back(CH_MINUS);
            1:       text_q.push_back(CH_PLUS);
            default: ;
        endcase
        b = int'(bsel);
        if (bsel == 0)
        begin
            case ($urandom_range(2))
                0:
                begin
                    text_q.push_back(CH_0);
                    text_q.push_back($urandom_range(1) ? CH_LX : CH_UX);
                    b = 16;
                end
                1:
                begin
                    text_q.push_back(CH_0);
                    b = 8;
                end
                default: b = 10;
            endcase
        end
        else if (bsel == 16 && $urandom_range(1))
        begin
            text_q.push_back(CH_0);
            text_q.push_back($urandom_range(1) ? CH_LX : CH_UX);
        end
        else if (bsel == 1 || bsel > ttip_pkg::MAX_BASE)
            b = $urandom_range(2, 36);

        if ($urandom_range(4) == 0)
        begin
            // values around the saturation limits
            case ($urandom_range(5))
                0:       v = 64'h0;
                1:       v = 64'h7FFF_FFFF;
                2:       v = 64'h8000_0000;
                3:       v = 64'h8000_0001;
                4:       v = 64'hFFFF_FFFF;
                default: v = 64'h1_0000_0000;
            endcase
            do
            begin
                rev.push_front(digit_glyph(int'(v % b)));
                v = v / b;
            end
            while (v != 0);
            foreach (rev[i])
                text_q.push_back(rev[i]);
        end
        else
        begin
            n = ($urandom_range(7) == 0) ? $urandom_range(8, 34) : $urandom_range(0, 8);
            repeat (n)
                text_q.push_back(digit_glyph($urandom_range(b - 1)));
        end
        text_q.push_back($urandom_range(1) ? 8'h00 : 8'($urandom_range(255)));
    endtask

    task automatic random_string(input logic [5:0] bsel);
        int k;
        int n;
        k = $urandom_range(99);
        if (k < 70)
        begin
            make_number(bsel);
            send_queued();
        end
        else if (k < 80)
        begin
            text_q.delete();
            repeat ($urandom_range(1, 6))
                text_q.push_back(8'($urandom_range(255)));
            send_queued();
        end
        else if (k < 88)
        begin
            // cut to a random length, possibly whole; later beats end it or a start abandons it
            make_number(bsel);
            n = $urandom_range(1, text_q.size());
            while (text_q.size() > n)
                void'(text_q.pop_back());
            send_queued();
        end
        else if (k < 95)
            send_beat(1'b0, 8'($urandom_range(255)));
        else
        begin
            text_q.delete();
            text_q.push_back(CH_SPACE);
            if ($urandom_range(1))
                text_q.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
            text_q.push_back(8'h00);
            send_queued();
        end
    endtask

    initial
    begin : stimulus
        logic [5:0] bsel;
        logic       uns;
        int         p;
        int         phase_start;
        bit         paused;

        rst_n      = 1'b0;
        char_valid = 1'b0;
        char_beat  = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        idling     = 1'b1;
        items_sent = 0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset config: base detect, unsigned saturation
        send_text("\t-0x1F", "g");
        send_text("07:", -1);
        send_text("0x!", -1);
        send_text("+", 0);
        send_beat(1'b0, 8'hFF);
        send_text("12", -1);
        send_text("5", 0);
        drain();
        set_config(6'd36, 1'b0);
        send_text("-zzzzzzz", 0);
        drain();
        set_config(6'd1, 1'b1);
        send_beat(1'b1, CH_UA);
        drain();

        p      = 0;
        paused = 1'b0;
        while (items_sent < ITEM_TARGET || p < 10)
        begin
            case (p)
                0:       begin bsel = 6'd0;  uns = 1'b1; end
                1:       begin bsel = 6'd2;  uns = 1'b0; end
                2:       begin bsel = 6'd36; uns = 1'b1; end
                3:       begin bsel = 6'd36; uns = 1'b0; end
                4:       begin bsel = 6'd16; uns = 1'b0; end
                5:       begin bsel = 6'd10; uns = 1'b0; end
                6:       begin bsel = 6'd1;  uns = 1'b1; end
                7:       begin bsel = 6'd8;  uns = 1'b1; end
                8:       begin bsel = 6'd63; uns = 1'b0; end
                9:       begin bsel = 6'd37; uns = 1'b1; end
                default:
                begin
                    if ($urandom_range(3) == 0)
                        bsel = 6'($urandom_range(63));
                    else
                    begin
                        bsel = 6'($urandom_range(36));
                        if (bsel == 6'd1)
                            bsel = 6'd0;
                    end
                    uns = 1'($urandom_range(1));
                end
            endcase
            set_config(bsel, uns);
            idling = (p != 3);

            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                random_string(bsel);
                if (p == 2 && !paused && items_sent - phase_start >= PHASE_ITEMS / 2)
                begin
                    drain();
                    paused = 1'b1;
                end
            end
            // close any open string before the next config write
            send_beat(1'b0, 8'h00);
            drain();
            p++;
        end

        idling = 1'b1;
        drain();
        repeat (10) @(negedge clk);
        if (mismatches == 0 && results_pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/ttip_pkg.sv
hw/rtl/text_to_integer_parser_unit.sv
sim/ttip_result_checker.sv
sim/tb.sv
